>>> rtl/maps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_pkg
// Shared types and constants for the multi-access path steering block.
// ----------------------------------------------------------------------------
package maps_pkg;

    // access codes
    localparam logic ACC_3GPP    = 1'b0;
    localparam logic ACC_NON3GPP = 1'b1;

    // decision source codes
    localparam logic [2:0] SRC_UPLINK   = 3'd0;
    localparam logic [2:0] SRC_NO_MAR   = 3'd1;
    localparam logic [2:0] SRC_MODE     = 3'd2;
    localparam logic [2:0] SRC_NO_STATE = 3'd3;
    localparam logic [2:0] SRC_RTT      = 3'd4;
    localparam logic [2:0] SRC_UNKNOWN  = 3'd5;

    // steering modes
    localparam logic [2:0] MODE_ACT_STBY = 3'd0;
    localparam logic [2:0] MODE_MIN_RTT  = 3'd1;
    localparam logic [2:0] MODE_LOAD_BAL = 3'd2;
    localparam logic [2:0] MODE_PRIORITY = 3'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_STEER_MODE = 3'd0;
    localparam logic [2:0] CFG_ACTIVE     = 3'd1;
    localparam logic [2:0] CFG_STANDBY    = 3'd2;
    localparam logic [2:0] CFG_PREFERRED  = 3'd3;
    localparam logic [2:0] CFG_SHARE      = 3'd4;
    localparam logic [2:0] CFG_STALE      = 3'd5;

    // reset values
    localparam logic [6:0]  SHARE_RESET = 7'd50;
    localparam logic [63:0] STALE_RESET = 64'd10_000_000_000;

    // flow hash: Knuth multiplier, product bits 31:16 taken modulo 100
    localparam logic [31:0] HASH_MULT  = 32'd2654435761;
    localparam int          HASH_SHIFT = 16;
    localparam logic [15:0] BUCKETS    = 16'd100;
    // floor(h / 100) = (h * 83887) >> 23, exact for every 16-bit h
    localparam logic [32:0] RECIP_100   = 33'd83887;
    localparam int          RECIP_SHIFT = 23;

    typedef struct packed {
        logic [2:0]  path_mode;
        logic        active_path;
        logic        standby_path;
        logic        preferred_path;
        logic [6:0]  share_3gpp_percent;
        logic [63:0] stale_limit_ns;
    } maps_cfg_t;

    // fields of one registered input transaction used by the decision
    typedef struct packed {
        logic        uplink_pkt;
        logic        mar_present;
        logic        state_present;
        logic [1:0]  path_down;
        logic [63:0] rtt_3gpp;
        logic [63:0] rtt_non3gpp;
        logic [63:0] rtt_stamp;
        logic [63:0] now_time;
    } maps_item_t;

    typedef struct packed {
        logic       sel;
        logic [2:0] src;
        logic       is_lb;
    } maps_pre_t;

    typedef struct packed {
        logic load2;
        logic load3;
    } maps_pipe_ctl_t;

endpackage

>>> rtl/multi_access_path_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_access_path_steering
// Per-packet egress access selection (3GPP N3 or non-3GPP N9).
// ----------------------------------------------------------------------------
// Takes one packet transaction per clock while in_stall is low and returns one
// decision per packet, in order. The pipeline is: input register; mode
// decision plus the Knuth hash multiply; the reciprocal multiply that divides
// the hash by 100; remainder, share compare and the output register.
// The two multiplies set the depth; sustained rate is one transaction per
// cycle whenever the output side does not stall. Each stage holds under
// backpressure, and in_stall rises only when every stage is full and the
// output is stalled. Configuration is written through cfg_we/cfg_index/
// cfg_data and must only change while no packet is in flight.
// ----------------------------------------------------------------------------
module multi_access_path_steering (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        uplink_pkt,
    input  logic        mar_present,
    input  logic        state_present,
    input  logic [1:0]  path_down,
    input  logic [63:0] rtt_3gpp,
    input  logic [63:0] rtt_non3gpp,
    input  logic [63:0] rtt_stamp,
    input  logic [63:0] now_time,
    input  logic [31:0] source_ip,
    input  logic [31:0] dest_ip,
    input  logic [31:0] port_pair,
    input  logic [7:0]  ip_protocol,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        egress_access,
    output logic        n9_override,
    output logic [2:0]  decision_source
);

    maps_pkg::maps_cfg_t      cfg;
    maps_pkg::maps_item_t     item_reg;
    maps_pkg::maps_pre_t      pre;
    maps_pkg::maps_pre_t      pre2_reg;
    maps_pkg::maps_pre_t      pre3_reg;
    maps_pkg::maps_pipe_ctl_t ctl;

    logic [31:0] sip_reg;
    logic [31:0] dip_reg;
    logic [31:0] ports_reg;
    logic [7:0]  proto_reg;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic load1, load_out;
    logic free1, free2, free3;
    logic to_3gpp;

    logic       sel_next;
    logic [2:0] src_next;
    logic       sel_reg;
    logic       redir_reg;
    logic [2:0] src_reg;

    maps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage advance: a stage loads when it has data and the next one frees up.
    assign load_out  = v3_reg && (!out_valid_reg || !out_stall);
    assign free3     = !v3_reg || load_out;
    assign ctl.load3 = v2_reg && free3;
    assign free2     = !v2_reg || ctl.load3;
    assign ctl.load2 = v1_reg && free2;
    assign free1     = !v1_reg || ctl.load2;
    assign load1     = in_valid && free1;
    assign in_stall  = !free1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= 1'b1;
            else if (ctl.load2)
                v1_reg <= 1'b0;

            if (ctl.load2)
                v2_reg <= 1'b1;
            else if (ctl.load3)
                v2_reg <= 1'b0;

            if (ctl.load3)
                v3_reg <= 1'b1;
            else if (load_out)
                v3_reg <= 1'b0;

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Stage 1: capture the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            item_reg.uplink_pkt    <= uplink_pkt;
            item_reg.mar_present   <= mar_present;
            item_reg.state_present <= state_present;
            item_reg.path_down     <= path_down;
            item_reg.rtt_3gpp      <= rtt_3gpp;
            item_reg.rtt_non3gpp   <= rtt_non3gpp;
            item_reg.rtt_stamp     <= rtt_stamp;
            item_reg.now_time      <= now_time;
            sip_reg                <= source_ip;
            dip_reg                <= dest_ip;
            ports_reg              <= port_pair;
            proto_reg              <= ip_protocol;
        end
    end

    // Stage 2: everything except the load-balance bucket is settled here.
    maps_decide u_decide (
        .item (item_reg),
        .cfg  (cfg),
        .pre  (pre)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
            pre2_reg <= pre;
        if (ctl.load3)
            pre3_reg <= pre2_reg;
    end

    maps_bucket u_bucket (
        .clk                (clk),
        .ctl                (ctl),
        .source_ip          (sip_reg),
        .dest_ip            (dip_reg),
        .port_pair          (ports_reg),
        .ip_protocol        (proto_reg),
        .share_3gpp_percent (cfg.share_3gpp_percent),
        .to_3gpp            (to_3gpp)
    );

    // Final: fold in the load-balance result, flag N9 overrides.
    assign sel_next = pre3_reg.is_lb ? ~to_3gpp : pre3_reg.sel;
    assign src_next = pre3_reg.src;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sel_reg   <= sel_next;
            src_reg   <= src_next;
            redir_reg <= (src_next >= maps_pkg::SRC_MODE) && (sel_next == maps_pkg::ACC_NON3GPP);
        end
    end

    assign out_valid       = out_valid_reg;
    assign egress_access   = sel_reg;
    assign n9_override     = redir_reg;
    assign decision_source = src_reg;

endmodule

>>> rtl/maps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module maps_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output maps_pkg::maps_cfg_t cfg
);

    maps_pkg::maps_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.path_mode          <= maps_pkg::MODE_ACT_STBY;
            cfg_reg.active_path        <= maps_pkg::ACC_3GPP;
            cfg_reg.standby_path       <= maps_pkg::ACC_NON3GPP;
            cfg_reg.preferred_path     <= maps_pkg::ACC_3GPP;
            cfg_reg.share_3gpp_percent <= maps_pkg::SHARE_RESET;
            cfg_reg.stale_limit_ns     <= maps_pkg::STALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                maps_pkg::CFG_STEER_MODE: cfg_reg.path_mode          <= cfg_data[2:0];
                maps_pkg::CFG_ACTIVE:     cfg_reg.active_path        <= cfg_data[0];
                maps_pkg::CFG_STANDBY:    cfg_reg.standby_path       <= cfg_data[0];
                maps_pkg::CFG_PREFERRED:  cfg_reg.preferred_path     <= cfg_data[0];
                maps_pkg::CFG_SHARE:      cfg_reg.share_3gpp_percent <= cfg_data[6:0];
                maps_pkg::CFG_STALE:      cfg_reg.stale_limit_ns     <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/maps_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_decide
// Mode decision for every mode but load balance, which is flagged.
// ----------------------------------------------------------------------------
module maps_decide (
    input  maps_pkg::maps_item_t item,
    input  maps_pkg::maps_cfg_t  cfg,
    output maps_pkg::maps_pre_t  pre
);

    logic [63:0] age;
    logic        rtt_bad;
    logic        non3gpp_faster;

    assign age            = item.now_time - item.rtt_stamp;
    assign rtt_bad        = (item.rtt_stamp == 64'd0) || (age > cfg.stale_limit_ns) ||
                            (item.rtt_3gpp == 64'd0) || (item.rtt_non3gpp == 64'd0);
    assign non3gpp_faster = item.rtt_non3gpp < item.rtt_3gpp;

    always_comb
    begin
        pre.sel   = maps_pkg::ACC_3GPP;
        pre.src   = maps_pkg::SRC_MODE;
        pre.is_lb = 1'b0;
        if (item.uplink_pkt)
        begin
            pre.src = maps_pkg::SRC_UPLINK;
        end
        else if (!item.mar_present)
        begin
            pre.src = maps_pkg::SRC_NO_MAR;
        end
        else
        begin
            case (cfg.path_mode)
                maps_pkg::MODE_ACT_STBY:
                begin
                    if (!item.state_present)
                    begin
                        pre.sel = cfg.active_path;
                        pre.src = maps_pkg::SRC_NO_STATE;
                    end
                    else
                    begin
                        pre.sel = item.path_down[cfg.active_path] ? cfg.standby_path
                                                                  : cfg.active_path;
                    end
                end
                maps_pkg::MODE_MIN_RTT:
                begin
                    if (!item.state_present)
                        pre.src = maps_pkg::SRC_NO_STATE;
                    else if (rtt_bad)
                        pre.src = maps_pkg::SRC_RTT;
                    else
                        pre.sel = non3gpp_faster ? maps_pkg::ACC_NON3GPP
                                                 : maps_pkg::ACC_3GPP;
                end
                maps_pkg::MODE_LOAD_BAL:
                begin
                    pre.is_lb = 1'b1;
                end
                maps_pkg::MODE_PRIORITY:
                begin
                    if (!item.state_present)
                    begin
                        pre.sel = cfg.preferred_path;
                        pre.src = maps_pkg::SRC_NO_STATE;
                    end
                    else
                    begin
                        pre.sel = item.path_down[cfg.preferred_path] ? ~cfg.preferred_path
                                                                     : cfg.preferred_path;
                    end
                end
                default:
                begin
                    pre.src = maps_pkg::SRC_UNKNOWN;
                end
            endcase
        end
    end

endmodule

>>> rtl/maps_bucket.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maps_bucket
// Two-stage flow hash: Knuth product, then bucket = bits 31:16 mod 100.
// ----------------------------------------------------------------------------
module maps_bucket (
    input  logic                    clk,
    input  maps_pkg::maps_pipe_ctl_t ctl,
    input  logic [31:0]             source_ip,
    input  logic [31:0]             dest_ip,
    input  logic [31:0]             port_pair,
    input  logic [7:0]              ip_protocol,
    input  logic [6:0]              share_3gpp_percent,
    output logic                    to_3gpp
);

    logic [31:0] folded;
    logic [31:0] product;
    logic [15:0] hash_reg;
    logic [15:0] hash3_reg;
    logic [32:0] recip_prod;
    logic [9:0]  quot_reg;
    logic [15:0] quot_x100;
    logic [15:0] bucket;

    assign folded  = source_ip ^ dest_ip ^ port_pair ^ {24'd0, ip_protocol};
    assign product = folded * maps_pkg::HASH_MULT;

    always_ff @(posedge clk)
    begin
        if (ctl.load2)
            hash_reg <= product[maps_pkg::HASH_SHIFT +: 16];
    end

    assign recip_prod = {17'd0, hash_reg} * maps_pkg::RECIP_100;

    always_ff @(posedge clk)
    begin
        if (ctl.load3)
        begin
            hash3_reg <= hash_reg;
            quot_reg  <= recip_prod[maps_pkg::RECIP_SHIFT +: 10];
        end
    end

    // remainder is below 100, so the compare needs only its low bits
    assign quot_x100 = {6'd0, quot_reg} * maps_pkg::BUCKETS;
    assign bucket    = hash3_reg - quot_x100;
    assign to_3gpp   = bucket < {9'd0, share_3gpp_percent};

endmodule
